// ===== hw/rtl/ycq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ycq_pkg;

    // Fixed-point coefficients, 12 fraction bits, held as positive signed values
    localparam logic signed [13:0] CoefCrRed   = 14'sh166f;  // 1.402
    localparam logic signed [13:0] CoefCbGreen = 14'sh0581;  // 0.344
    localparam logic signed [13:0] CoefCrGreen = 14'sh0b6d;  // 0.714
    localparam logic signed [13:0] CoefCbBlue  = 14'sh1c5b;  // 1.772
    localparam logic [7:0]         ChromaBias  = 8'd128;

    localparam int CoefW  = 14;
    localparam int ChromW = 9;
    localparam int ProdW  = CoefW + ChromW;   // 9 x 14 signed product
    localparam int SumW   = ProdW + 1;        // green term sum
    localparam int FracW  = 12;
    localparam int OffW   = 9;                // offsets stay within -256..255
    localparam int PixSumW = 11;              // luma plus offset, signed

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } quad_t;

    typedef struct packed {
        logic [15:0] pixel_top_left;
        logic [15:0] pixel_top_right;
        logic [15:0] pixel_bottom_left;
        logic [15:0] pixel_bottom_right;
    } pixels_t;

    // Luma samples in order top left, top right, bottom left, bottom right
    typedef logic [3:0][7:0] luma_quad_t;

    typedef struct packed {
        luma_quad_t                luma;
        logic signed [ProdW-1:0]   red_prod;
        logic signed [ProdW-1:0]   cb_green_prod;
        logic signed [ProdW-1:0]   cr_green_prod;
        logic signed [ProdW-1:0]   blue_prod;
    } prod_t;

    typedef struct packed {
        luma_quad_t              luma;
        logic signed [OffW-1:0]  red;
        logic signed [OffW-1:0]  green;
        logic signed [OffW-1:0]  blue;
    } offs_t;

    // Saturate a signed sum to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [PixSumW-1:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > 255)
        begin
            res = 8'hff;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    // Pack clamped channels as RGB565
    function automatic logic [15:0] pack565(input logic [7:0] r,
                                            input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ycbcr420_quad_to_rgb565_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An accepted quad reaches the output through the product, offset and output registers in turn.
// Throughput: one quad per cycle while pixel_ready holds, set by the three register stages
// (products, offsets, clamp and pack), each of which refills as it drains.
// Stalls propagate back through full stages in the same cycle; a bubble is filled at once.
// Reset (rst_n low, asynchronous) empties all stages; payload is not cleared.
module ycbcr420_quad_to_rgb565_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           quad_valid,
    output logic                quad_ready,
    input  wire ycq_pkg::quad_t quad,
    output logic                pixel_valid,
    input  wire logic           pixel_ready,
    output ycq_pkg::pixels_t    pixels
);

    logic           offs_valid;
    logic           offs_ready;
    ycq_pkg::offs_t offs;

    // Chroma offsets over two stages
    ycq_chroma u_chroma (
        .clk        (clk),
        .rst_n      (rst_n),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad),
        .offs_valid (offs_valid),
        .offs_ready (offs_ready),
        .offs       (offs)
    );

    // Per-pixel add, clamp and pack into the output register
    ycq_pixel u_pixel (
        .clk         (clk),
        .rst_n       (rst_n),
        .offs_valid  (offs_valid),
        .offs_ready  (offs_ready),
        .offs        (offs),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixels      (pixels)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ycq_chroma.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ycq_chroma (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          quad_valid,
    output logic               quad_ready,
    input  wire ycq_pkg::quad_t quad,
    output logic               offs_valid,
    input  wire logic          offs_ready,
    output ycq_pkg::offs_t     offs
);

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    ycq_pkg::prod_t            s1_reg;
    ycq_pkg::prod_t            s1_next;
    logic                      s1_ready;

    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    ycq_pkg::offs_t            s2_reg;
    ycq_pkg::offs_t            s2_next;
    logic                      s2_ready;

    logic signed [ycq_pkg::ChromW-1:0] cb;
    logic signed [ycq_pkg::ChromW-1:0] cr;
    logic signed [ycq_pkg::SumW-1:0]   green_sum;
    logic signed [ycq_pkg::ProdW-1:0]  red_shift;
    logic signed [ycq_pkg::SumW-1:0]   green_shift;
    logic signed [ycq_pkg::ProdW-1:0]  blue_shift;

    // Stage handshakes: a stage takes a request when empty or when it drains
    assign s2_ready   = !s2_valid_reg || offs_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign quad_ready = s1_ready;

    // Remove the chroma bias and form the four products
    always_comb
    begin
        cb = $signed({1'b0, quad.chroma_blue}) - $signed({1'b0, ycq_pkg::ChromaBias});
        cr = $signed({1'b0, quad.chroma_red}) - $signed({1'b0, ycq_pkg::ChromaBias});
        s1_next.luma          = {quad.luma_top_left, quad.luma_top_right,
                                 quad.luma_bottom_left, quad.luma_bottom_right};
        s1_next.red_prod      = cr * ycq_pkg::CoefCrRed;
        s1_next.cb_green_prod = cb * ycq_pkg::CoefCbGreen;
        s1_next.cr_green_prod = cr * ycq_pkg::CoefCrGreen;
        s1_next.blue_prod     = cb * ycq_pkg::CoefCbBlue;
        s1_valid_next         = s1_ready ? quad_valid : s1_valid_reg;
    end

    // Sum the green terms and floor every offset by the arithmetic shift
    always_comb
    begin
        green_sum   = ycq_pkg::SumW'(s1_reg.cb_green_prod)
                    + ycq_pkg::SumW'(s1_reg.cr_green_prod);
        red_shift   = s1_reg.red_prod >>> ycq_pkg::FracW;
        green_shift = green_sum >>> ycq_pkg::FracW;
        blue_shift  = s1_reg.blue_prod >>> ycq_pkg::FracW;
        s2_next.luma  = s1_reg.luma;
        s2_next.red   = red_shift[ycq_pkg::OffW-1:0];
        s2_next.green = green_shift[ycq_pkg::OffW-1:0];
        s2_next.blue  = blue_shift[ycq_pkg::OffW-1:0];
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Advance the payload; hold it while the stage stalls
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    assign offs_valid = s2_valid_reg;
    assign offs       = s2_reg;

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> quad_ready)
        else $error("empty product stage refused a request");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> s2_valid_reg)
        else $error("product stage request lost on the way to the offset stage");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !offs_ready |=> s2_valid_reg && $stable(s2_reg))
        else $error("stalled offset stage dropped or changed its request");

endmodule

`default_nettype wire

// ===== hw/rtl/ycq_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ycq_pixel (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           offs_valid,
    output logic                offs_ready,
    input  wire ycq_pkg::offs_t offs,
    output logic                pixel_valid,
    input  wire logic           pixel_ready,
    output ycq_pkg::pixels_t    pixels
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    ycq_pkg::pixels_t       out_reg;
    ycq_pkg::pixels_t       out_next;
    logic [3:0][15:0]       packed_pix;

    assign offs_ready = !out_valid_reg || pixel_ready;

    // Add offsets to each luma, clamp and pack
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [ycq_pkg::PixSumW-1:0] y;
            logic signed [ycq_pkg::PixSumW-1:0] r_sum;
            logic signed [ycq_pkg::PixSumW-1:0] g_sum;
            logic signed [ycq_pkg::PixSumW-1:0] b_sum;
            y     = $signed({3'b000, offs.luma[i]});
            r_sum = y + ycq_pkg::PixSumW'(offs.red);
            g_sum = y - ycq_pkg::PixSumW'(offs.green);
            b_sum = y + ycq_pkg::PixSumW'(offs.blue);
            packed_pix[i] = ycq_pkg::pack565(ycq_pkg::clamp_byte(r_sum),
                                             ycq_pkg::clamp_byte(g_sum),
                                             ycq_pkg::clamp_byte(b_sum));
        end
        out_next.pixel_top_left     = packed_pix[3];
        out_next.pixel_top_right    = packed_pix[2];
        out_next.pixel_bottom_left  = packed_pix[1];
        out_next.pixel_bottom_right = packed_pix[0];
        out_valid_next = offs_ready ? offs_valid : out_valid_reg;
    end

    // Advance the output valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register when it drains or is empty
    always_ff @(posedge clk)
    begin
        if (offs_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixels      = out_reg;

    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        offs_valid && offs_ready |=> pixel_valid)
        else $error("accepted offset request did not reach the output");

    a_drain_frees: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_ready |-> offs_ready)
        else $error("output stage stalled although the consumer is ready");

endmodule

`default_nettype wire
